### sv/ghbac_pkg.sv
`timescale 1ns / 1ps

package ghbac_pkg;

  // fixed field widths
  localparam int ADDR_W = 64;
  localparam int DEG_W  = 5;

  // prefetch degree after reset
  localparam logic [DEG_W-1:0] DEG_RESET = 5'd16;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_STEP,
    ST_HIST,
    ST_FLUSH,
    ST_PUSH
  } ghbac_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_en;
    logic idx_rd;
    logic start_load;
    logic hist_rd;
    logic hist_load;
    logic pend_set;
    logic out_mid;
    logic out_last;
    logic push;
  } ghbac_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic walk_go;
    logic cand_valid;
    logic pend_valid;
    logic out_free;
  } ghbac_sts_t;

endpackage

### sv/ghbac_req_if.sv
`timescale 1ns / 1ps

interface ghbac_req_if;
  import ghbac_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] access_addr;
  logic              was_hit;

  modport source (output valid, output access_addr, output was_hit, input ready);
  modport sink (input valid, input access_addr, input was_hit, output ready);
endinterface

### sv/ghbac_pf_if.sv
`timescale 1ns / 1ps

interface ghbac_pf_if;
  import ghbac_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] prefetch_addr;
  logic              last_of_run;

  modport source (output valid, output prefetch_addr, output last_of_run, input ready);
  modport sink (input valid, input prefetch_addr, input last_of_run, output ready);
endinterface

### sv/ghbac_ctrl.sv
`timescale 1ns / 1ps

module ghbac_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_was_hit,
  output logic                in_ready,
  input  ghbac_pkg::ghbac_sts_t sts,
  output ghbac_pkg::ghbac_cmd_t cmd
);
  import ghbac_pkg::*;

  ghbac_state_t state_r, state_nxt;
  logic         hist_go;

  // a step may retire unless a pending prefetch must move out to a busy output
  assign hist_go = !sts.cand_valid || !sts.pend_valid || sts.out_free;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && !in_was_hit) state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        state_nxt = sts.walk_go ? ST_HIST : ST_FLUSH;
      end
      ST_HIST: begin
        if (hist_go) state_nxt = ST_STEP;
      end
      ST_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.idx_rd = in_valid && !in_was_hit;
      end
      ST_START: begin
        cmd.start_load = 1'b1;
      end
      ST_STEP: begin
        cmd.hist_rd = sts.walk_go;
      end
      ST_HIST: begin
        cmd.hist_load = hist_go;
        cmd.pend_set  = hist_go && sts.cand_valid && !sts.pend_valid;
        cmd.out_mid   = hist_go && sts.cand_valid && sts.pend_valid;
      end
      ST_FLUSH: begin
        cmd.out_last = sts.pend_valid && sts.out_free;
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### sv/ghbac_dpath.sv
`timescale 1ns / 1ps

module ghbac_dpath #(
  parameter int INDEX_ENTRIES   = 1024,
  parameter int HISTORY_ENTRIES = 1024,
  parameter int POINTER_SPAN    = 16384,
  parameter int MAX_DEGREE      = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ghbac_pkg::ADDR_W-1:0]    in_access_addr,
  input  logic                            cfg_we,
  input  logic [ghbac_pkg::DEG_W-1:0]     cfg_wdata,
  input  ghbac_pkg::ghbac_cmd_t           cmd,
  output ghbac_pkg::ghbac_sts_t           sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ghbac_pkg::ADDR_W-1:0]    out_prefetch_addr,
  output logic                            out_last_of_run
);
  import ghbac_pkg::*;

  localparam int IW    = $clog2(INDEX_ENTRIES);
  localparam int HW    = $clog2(HISTORY_ENTRIES);
  localparam int PW    = $clog2(POINTER_SPAN);
  localparam int SW    = $clog2(MAX_DEGREE + 1);
  localparam int XW    = (SW > DEG_W) ? SW : DEG_W;
  localparam int CLR_N = (INDEX_ENTRIES > HISTORY_ENTRIES) ? INDEX_ENTRIES : HISTORY_ENTRIES;
  localparam int CW    = $clog2(CLR_N);

  // memories: index and link entries are {valid, pointer}, history entries an address
  logic [PW:0]       idx_mem  [INDEX_ENTRIES];
  logic [ADDR_W-1:0] addr_mem [HISTORY_ENTRIES];
  logic [PW:0]       link_mem [HISTORY_ENTRIES];

  logic [DEG_W-1:0]  deg_r;
  logic [CW-1:0]     clr_cnt_r;
  logic [PW-1:0]     head_r;
  logic [ADDR_W-1:0] addr_r;
  logic [IW-1:0]     idx_r;
  logic [PW:0]       idx_rd_r;
  logic [ADDR_W-1:0] hist_addr_rd_r;
  logic [PW:0]       link_rd_r;
  logic              start_use_r;
  logic [PW-1:0]     start_ptr_r;
  logic              walk_valid_r;
  logic [PW-1:0]     walk_ptr_r;
  logic [SW-1:0]     steps_r;
  logic [HW-1:0]     next_slot_r;
  logic              pend_valid_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_last_r;

  logic [HW-1:0]     head_slot;
  logic [HW-1:0]     walk_next;
  logic [SW-1:0]     steps_init;
  logic              idx_we;
  logic [IW-1:0]     idx_wa;
  logic [PW:0]       idx_wd;
  logic              hist_we;
  logic [HW-1:0]     hist_wa;
  logic [ADDR_W-1:0] addr_wd;
  logic [PW:0]       link_wd;

  // pointer is live when 0 < (head - ptr) mod span <= history depth
  function automatic logic usable(input logic v, input logic [PW-1:0] p,
                                  input logic [PW-1:0] h);
    logic [PW-1:0] d;
    d = h - p;
    return v && (d != '0) && ({1'b0, d} <= (PW+1)'(HISTORY_ENTRIES));
  endfunction

  assign head_slot  = head_r[HW-1:0];
  assign walk_next  = walk_ptr_r[HW-1:0] + HW'(1);
  assign steps_init = (XW'(deg_r) > XW'(MAX_DEGREE)) ? SW'(MAX_DEGREE) : SW'(deg_r);

  // degree register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= DEG_RESET;
    end else if (cfg_we) begin
      deg_r <= cfg_wdata;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + CW'(1);
    end
  end

  // write port muxing between the sweep and the miss push
  always_comb begin
    if (cmd.clr_en) begin
      idx_we  = ({1'b0, clr_cnt_r} < (CW+1)'(INDEX_ENTRIES));
      idx_wa  = clr_cnt_r[IW-1:0];
      idx_wd  = '0;
      hist_we = ({1'b0, clr_cnt_r} < (CW+1)'(HISTORY_ENTRIES));
      hist_wa = clr_cnt_r[HW-1:0];
      addr_wd = '0;
      link_wd = {1'b1, {PW{1'b0}}};
    end else begin
      idx_we  = cmd.push;
      idx_wa  = idx_r;
      idx_wd  = {1'b1, head_r};
      hist_we = cmd.push;
      hist_wa = head_slot;
      addr_wd = addr_r;
      link_wd = start_use_r ? {1'b1, start_ptr_r} : '0;
    end
  end

  // index table
  always_ff @(posedge clk) begin
    if (idx_we) idx_mem[idx_wa] <= idx_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_rd) idx_rd_r <= idx_mem[in_access_addr[IW-1:0]];
  end

  // history buffer
  always_ff @(posedge clk) begin
    if (hist_we) begin
      addr_mem[hist_wa] <= addr_wd;
      link_mem[hist_wa] <= link_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_rd) begin
      hist_addr_rd_r <= addr_mem[walk_next];
      link_rd_r      <= link_mem[walk_next];
    end
  end

  // head pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else if (cmd.push) begin
      head_r <= head_r + PW'(1);
    end
  end

  // miss request capture
  always_ff @(posedge clk) begin
    if (cmd.idx_rd) begin
      addr_r <= in_access_addr;
      idx_r  <= in_access_addr[IW-1:0];
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      start_use_r  <= usable(idx_rd_r[PW], idx_rd_r[PW-1:0], head_r);
      start_ptr_r  <= idx_rd_r[PW-1:0];
      walk_valid_r <= idx_rd_r[PW];
      walk_ptr_r   <= idx_rd_r[PW-1:0];
      steps_r      <= steps_init;
    end else if (cmd.hist_load) begin
      walk_valid_r <= link_rd_r[PW];
      walk_ptr_r   <= link_rd_r[PW-1:0];
      steps_r      <= steps_r - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_rd) next_slot_r <= walk_next;
  end

  // one-deep lookahead so the last prefetch of a run can be flagged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.pend_set || cmd.out_mid) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.out_last) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_set || cmd.out_mid) pend_addr_r <= hist_addr_rd_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_mid || cmd.out_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_mid || cmd.out_last) begin
      out_addr_r <= pend_addr_r;
      out_last_r <= cmd.out_last;
    end
  end

  // status back to the controller
  assign sts.clr_done   = (clr_cnt_r == CW'(CLR_N - 1));
  assign sts.walk_go    = (steps_r != '0) && usable(walk_valid_r, walk_ptr_r, head_r);
  assign sts.cand_valid = (next_slot_r != head_slot);
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_prefetch_addr = out_addr_r;
  assign out_last_of_run   = out_last_r;

endmodule

### sv/ghb_address_correlation_prefetcher.sv
// hit: accepted while idle, ready again the next cycle, no prefetch
// miss with k chain steps walked: one index read then one
//   history-buffer read per step, plus stalls while the output is held
// one request at a time; a prefetch is held until the next one is found or the walk ends
// reset: synchronous active-low; then a clearing sweep over max(INDEX_ENTRIES,
//   HISTORY_ENTRIES) entries (1024 by default) before the first request is taken
`timescale 1ns / 1ps

module ghb_address_correlation_prefetcher #(
  parameter int INDEX_ENTRIES   = 1024,
  parameter int HISTORY_ENTRIES = 1024,
  parameter int POINTER_SPAN    = 16384,
  parameter int MAX_DEGREE      = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ghbac_req_if.sink                   in_req,
  ghbac_pf_if.source                  out_pf,
  input  logic                        cfg_we,
  input  logic [ghbac_pkg::DEG_W-1:0] cfg_wdata
);
  import ghbac_pkg::*;

  ghbac_cmd_t cmd;
  ghbac_sts_t sts;

  // sequencer
  ghbac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_was_hit (in_req.was_hit),
    .in_ready   (in_req.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // tables, walk registers and output stage
  ghbac_dpath #(
    .INDEX_ENTRIES   (INDEX_ENTRIES),
    .HISTORY_ENTRIES (HISTORY_ENTRIES),
    .POINTER_SPAN    (POINTER_SPAN),
    .MAX_DEGREE      (MAX_DEGREE)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_access_addr    (in_req.access_addr),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_pf.ready),
    .out_valid         (out_pf.valid),
    .out_prefetch_addr (out_pf.prefetch_addr),
    .out_last_of_run   (out_pf.last_of_run)
  );

endmodule

### sv/ghbac_chk.sv
`timescale 1ns / 1ps

module ghbac_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_was_hit,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ghbac_pkg::ADDR_W-1:0] out_prefetch_addr,
  input logic                        out_last_of_run
);
  import ghbac_pkg::*;

  // a stalled prefetch holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prefetch_addr)
                                && $stable(out_last_of_run))
    else $error("prefetch changed while stalled");

  // reset starts the clearing sweep, no request taken
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request port ready right after reset");

  // a miss occupies the block and drops ready
  a_miss_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_was_hit |=> !in_ready)
    else $error("ready right after a miss");

  // a hit leaves the block ready
  a_hit_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_was_hit |=> in_ready)
    else $error("not ready after a hit");

endmodule

bind ghb_address_correlation_prefetcher ghbac_chk u_ghbac_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .in_was_hit        (in_req.was_hit),
  .out_valid         (out_pf.valid),
  .out_ready         (out_pf.ready),
  .out_prefetch_addr (out_pf.prefetch_addr),
  .out_last_of_run   (out_pf.last_of_run)
);

### dv/tb_ghb_address_correlation_prefetcher.sv
`timescale 1ns / 1ps

module tb_ghb_address_correlation_prefetcher;
  import ghbac_pkg::*;

  localparam int INDEX_ENTRIES   = 1024;
  localparam int HISTORY_ENTRIES = 1024;
  localparam int POINTER_SPAN    = 16384;
  localparam int MAX_DEGREE      = 16;
  localparam int IDX_W           = $clog2(INDEX_ENTRIES);
  localparam int SLOT_W          = $clog2(HISTORY_ENTRIES);
  localparam int PTR_W           = $clog2(POINTER_SPAN);

  localparam int DRAIN_CYCLES  = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_MISSES  = 28;
  localparam int NUM_PHASES    = 6;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last;
  } pf_t;

  // shadow of the history buffer; predicts the prefetch stream per miss
  class pf_tracker;
    bit [DEG_W-1:0]  degree;
    bit              idx_valid[INDEX_ENTRIES];
    bit [PTR_W-1:0]  idx_ptr[INDEX_ENTRIES];
    bit [ADDR_W-1:0] hist_addr[HISTORY_ENTRIES];
    bit              link_valid[HISTORY_ENTRIES];
    bit [PTR_W-1:0]  link_ptr[HISTORY_ENTRIES];
    bit [PTR_W-1:0]  head;
    pf_t             pending_pf[$];
    int              errors;

    function new();
      degree = DEG_RESET;
      for (int i = 0; i < INDEX_ENTRIES; i++) begin
        idx_valid[i] = 0;
        idx_ptr[i]   = '0;
      end
      for (int i = 0; i < HISTORY_ENTRIES; i++) begin
        hist_addr[i]  = '0;
        link_valid[i] = 1;
        link_ptr[i]   = '0;
      end
      head   = '0;
      errors = 0;
    endfunction

    // a pointer is live if it lies within one buffer length behind head
    function bit usable(bit v, bit [PTR_W-1:0] p);
      bit [PTR_W-1:0] gap;
      gap = head - p;
      return v && gap != 0 && gap <= HISTORY_ENTRIES;
    endfunction

    function void record_access(logic [ADDR_W-1:0] addr, logic hit);
      bit [IDX_W-1:0]    idx;
      bit [SLOT_W-1:0]   head_slot;
      bit [SLOT_W-1:0]   nxt;
      bit                start_v;
      bit                v;
      bit                walking;
      bit [PTR_W-1:0]    start_p;
      bit [PTR_W-1:0]    p;
      int                steps;
      logic [ADDR_W-1:0] found[$];
      if (hit) return;
      idx       = addr[IDX_W-1:0];
      start_v   = idx_valid[idx];
      start_p   = idx_ptr[idx];
      steps     = (degree > MAX_DEGREE) ? MAX_DEGREE : degree;
      head_slot = head[SLOT_W-1:0];

      // walk the chain of earlier occurrences
      v       = start_v;
      p       = start_p;
      walking = 1;
      for (int i = 0; i < steps; i++) begin
        if (walking && usable(v, p)) begin
          nxt = p[SLOT_W-1:0] + 1'b1;
          if (nxt != head_slot) found.push_back(hist_addr[nxt]);
          v = link_valid[nxt];
          p = link_ptr[nxt];
        end else begin
          walking = 0;
        end
      end
      foreach (found[k]) pending_pf.push_back(pf_t'{found[k], k == found.size() - 1});

      // push the miss at head
      idx_valid[idx]      = 1;
      idx_ptr[idx]        = head;
      hist_addr[head_slot] = addr;
      if (usable(start_v, start_p)) begin
        link_valid[head_slot] = 1;
        link_ptr[head_slot]   = start_p;
      end else begin
        link_valid[head_slot] = 0;
        link_ptr[head_slot]   = '0;
      end
      head = head + 1'b1;
    endfunction

    function void check_prefetch(logic [ADDR_W-1:0] addr, logic last);
      pf_t exp_pf;
      if (pending_pf.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected prefetch addr=%h last=%b", addr, last);
        return;
      end
      exp_pf = pending_pf.pop_front();
      if (exp_pf.addr !== addr || exp_pf.last !== last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("prefetch mismatch: expected addr=%h last=%b, got addr=%h last=%b",
                   exp_pf.addr, exp_pf.last, addr, last);
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [DEG_W-1:0] cfg_wdata;

  ghbac_req_if req_if();
  ghbac_pf_if  pf_if();

  pf_tracker sb;

  int src_idle_pct;
  int snk_stall_pct;
  int hold_token;
  int hold_seen = 0;
  int hold_left = 0;

  ghb_address_correlation_prefetcher #(
    .INDEX_ENTRIES  (INDEX_ENTRIES),
    .HISTORY_ENTRIES(HISTORY_ENTRIES),
    .POINTER_SPAN   (POINTER_SPAN),
    .MAX_DEGREE     (MAX_DEGREE)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_pf   (pf_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // prefetch sink: check handshakes, drive ready with random stalls and long hold-offs
  always @(posedge clk) begin
    if (rst_n && pf_if.valid && pf_if.ready)
      sb.check_prefetch(pf_if.prefetch_addr, pf_if.last_of_run);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pf_if.ready <= 1'b0;
    end else begin
      pf_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // offer one request and wait until it is taken; valid stays high afterward
  task automatic send_request(logic [ADDR_W-1:0] addr, logic hit);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.access_addr <= addr;
    req_if.was_hit     <= hit;
    do @(posedge clk); while (!req_if.ready);
    sb.record_access(addr, hit);
  endtask

  task automatic wait_results_done();
    while (sb.pending_pf.size() != 0) @(posedge clk);
  endtask

  // drain the block, then write the degree register
  task automatic set_degree(logic [DEG_W-1:0] d);
    req_if.valid <= 1'b0;
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.degree = d;
  endtask

  task automatic set_idling(int src_pct, int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  initial begin
    logic [ADDR_W-1:0] seq_addr[26];
    bit                seq_hit[26];
    logic [ADDR_W-1:0] pool[16];
    int                stream[8];
    int                stream_len;
    int                stream_pos;
    int                misses;
    int                r;
    int                src_pct[4];
    int                snk_pct[4];
    logic [DEG_W-1:0]  phase_deg[NUM_PHASES];
    logic [ADDR_W-1:0] a;

    sb = new();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_token    = 0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_if.valid       <= 1'b0;
    req_if.access_addr <= '0;
    req_if.was_hit     <= 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_degree(5'd16);

    // directed: extremes, repeats onto the head slot, chains, index aliasing, hits
    seq_addr = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hA5A5_0000_1234_5101, 64'h0123_4567_89AB_C0FF, 64'h0,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5_0000_1234_5101,
                 64'h0123_4567_89AB_C0FF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0000, 64'h0, 64'h7FFF_FFFF_FFFF_F1FE, 64'h0,
                 64'h0123_4567_89AB_C0FF, 64'hA5A5_0000_1234_5101,
                 64'h0123_4567_89AB_C0FF, 64'hA5A5_0000_1234_5101,
                 64'h0, 64'hA5A5_0000_1234_5101, 64'h0123_4567_89AB_C0FF, 64'h0,
                 64'hA5A5_0000_1234_5101, 64'h0123_4567_89AB_C0FF};
    seq_hit  = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0,
                 0, 0, 0, 0, 0, 0};
    for (int i = 0; i < 20; i++) send_request(seq_addr[i], seq_hit[i]);

    // revisit the chains with some idling on both sides
    set_idling(24, 24);
    for (int i = 20; i < 26; i++) send_request(seq_addr[i], seq_hit[i]);
    set_idling(0, 0);

    // random: recurring miss streams over a small pool, some aliasing on the index
    foreach (pool[k]) pool[k] = {$urandom, $urandom};
    for (int k = 0; k < 4; k++) pool[k][IDX_W-1:0] = pool[k + 4][IDX_W-1:0];
    stream_len = 5;
    stream_pos = 0;
    foreach (stream[k]) stream[k] = $urandom_range(0, 15);
    src_pct   = '{0, 77, 0, 24};
    snk_pct   = '{0, 0, 77, 24};
    phase_deg = '{5'd16, 5'd1, 5'd31, 5'($urandom_range(2, 15)), 5'd0,
                  5'($urandom_range(17, 30))};

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_degree(phase_deg[ph]);
      set_idling(src_pct[ph % 4], snk_pct[ph % 4]);
      misses = 0;
      while (misses < PHASE_MISSES) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_request({$urandom, $urandom}, 1);
        end else begin
          if (r < 22) begin
            a = {$urandom, $urandom};
          end else begin
            if (stream_pos >= stream_len) begin
              stream_pos = 0;
              if ($urandom_range(0, 2) == 0) begin
                stream_len = $urandom_range(3, 8);
                foreach (stream[k]) stream[k] = $urandom_range(0, 15);
              end
            end
            a = pool[stream[stream_pos]];
            stream_pos++;
          end
          send_request(a, 0);
          misses++;
          // long receiver hold-off while requests keep coming
          if (ph == 0 && misses == 10) hold_token <= hold_token + 1;
          // sender pause until all prefetches are out
          if (ph == 1 && misses == 20) begin
            req_if.valid <= 1'b0;
            wait_results_done();
          end
        end
      end
    end

    // drain and report
    req_if.valid <= 1'b0;
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pf.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### ghb_address_correlation_prefetcher.f
sv/ghbac_pkg.sv
sv/ghbac_req_if.sv
sv/ghbac_pf_if.sv
sv/ghbac_ctrl.sv
sv/ghbac_dpath.sv
sv/ghb_address_correlation_prefetcher.sv
sv/ghbac_chk.sv
dv/tb_ghb_address_correlation_prefetcher.sv
